### rtl/core/issa_pkg.sv
// ----------------------------------------------------------------------------
// issa_pkg: shared definitions for the image shift, scale and accumulate block
// Widths, fixed-point constants, register indices, state codes and the
// structures that pass between the block's modules.
// ----------------------------------------------------------------------------
package issa_pkg;

   // Window store geometry and fixed-point formats
   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int FRAC_BITS  = 8;
   localparam int GAIN_FRAC  = 16;

   localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);

   // Field and register widths
   localparam int POS_W      = 8;
   localparam int PIX_W      = 32;
   localparam int SHIFT_W    = 17;
   localparam int GAIN_W     = 24;
   localparam int DIM_W      = 9;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   // Derived arithmetic widths
   localparam int RND_W   = SHIFT_W + 1;
   localparam int D_W     = SHIFT_W - FRAC_BITS + 1;
   localparam int DIFF_W  = ((D_W > POS_W + 1) ? D_W : POS_W + 1) + 1;
   localparam int WT1_W   = FRAC_BITS + 1;
   localparam int WT_W    = 2 * FRAC_BITS + 1;
   localparam int ACC_W   = PIX_W + 2 * FRAC_BITS + 1;
   localparam int GPROD_W = PIX_W + GAIN_W;
   localparam int TERM_W  = GPROD_W - GAIN_FRAC;
   localparam int TOTAL_W = TERM_W + 1;

   // Fixed-point constants
   localparam int ONE        = 2 ** FRAC_BITS;
   localparam int HALF       = ONE / 2;
   localparam int ACC_ROUND  = 2 ** (2 * FRAC_BITS - 1);
   localparam int GAIN_ROUND = 2 ** (GAIN_FRAC - 1);

   typedef enum logic {
      CMD_LOAD  = 1'b0,
      CMD_ACCUM = 1'b1
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INTERP_MODE = 3'd0,
      CSR_SHIFT_X     = 3'd1,
      CSR_SHIFT_Y     = 3'd2,
      CSR_GAIN        = 3'd3,
      CSR_WIDTH       = 3'd4,
      CSR_HEIGHT      = 3'd5,
      CSR_ENABLE      = 3'd6
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_DRAIN,
      ST_GAIN,
      ST_TERM,
      ST_SUM
   } state_type;

   // Configuration as the datapath sees it, already reduced to shifts,
   // fractions and clamp limits.
   typedef struct packed {
      logic                      interp_mode;
      logic                      enable;
      logic signed [GAIN_W-1:0]  gain;
      logic signed [D_W-1:0]     dx;
      logic signed [D_W-1:0]     dy;
      logic [FRAC_BITS-1:0]      rx;
      logic [FRAC_BITS-1:0]      ry;
      logic [COL_W-1:0]          col_max;
      logic [ROW_W-1:0]          row_max;
   } cfg_type;

   typedef struct packed {
      logic              en;
      logic              we;
      logic [ADDR_W-1:0] addr;
      logic [PIX_W-1:0]  wdata;
   } mem_req_type;

endpackage

### rtl/core/issa_req_if.sv
// ----------------------------------------------------------------------------
// issa_req_if: request channel
// Carries load and accumulate requests with their position and pixel value.
// ----------------------------------------------------------------------------
interface issa_req_if import issa_pkg::*;;
   logic                    valid;
   logic                    ready;
   logic                    command;
   logic [POS_W-1:0]        pos_x;
   logic [POS_W-1:0]        pos_y;
   logic signed [PIX_W-1:0] pixel_value;

   modport source (output valid, command, pos_x, pos_y, pixel_value, input ready);
   modport sink (input valid, command, pos_x, pos_y, pixel_value, output ready);
endinterface

### rtl/core/issa_rsp_if.sv
// ----------------------------------------------------------------------------
// issa_rsp_if: response channel
// Carries the updated sum pixel and its saturation flag.
// ----------------------------------------------------------------------------
interface issa_rsp_if import issa_pkg::*;;
   logic                    valid;
   logic                    ready;
   logic signed [PIX_W-1:0] sum_value;
   logic                    saturated;

   modport source (output valid, sum_value, saturated, input ready);
   modport sink (input valid, sum_value, saturated, output ready);
endinterface

### rtl/core/issa_csr_if.sv
// ----------------------------------------------------------------------------
// issa_csr_if: configuration write channel
// Carries a register index and the data to be written to that register.
// ----------------------------------------------------------------------------
interface issa_csr_if import issa_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/image_shift_scale_accumulate.sv
// ----------------------------------------------------------------------------
// image_shift_scale_accumulate: shift, scale and add one image window
// Top level joining the configuration registers, the window store and the
// accumulate engine.
// ----------------------------------------------------------------------------
// A load request writes one source pixel into the window store in the cycle
// it is accepted. An accumulate request adds gain times the shifted,
// optionally bilinearly interpolated, source pixel to the given sum. Its
// steps, in order: up to four neighbour reads (ST_READ), which share the
// store's single port; the drain of the multiply-accumulate pipeline behind
// the read (ST_DRAIN); the gain multiply (ST_GAIN) and its rounding
// (ST_TERM); and the add and saturate (ST_SUM). No new request is taken until
// the engine is back in ST_IDLE. With enable clear an accumulate goes straight
// to the add and saturate. A response that is not taken holds the engine in
// its final step once the next result is ready. The store is not cleared after
// reset; an entry reads as undefined until it has been loaded.
module image_shift_scale_accumulate import issa_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   issa_req_if.sink     req_chan,
   issa_rsp_if.source   rsp_chan,
   issa_csr_if.sink     csr_chan
);

   cfg_type          cfg;
   mem_req_type      mem_req;
   logic [PIX_W-1:0] mem_rdata;

   issa_regs u_regs (
      .clock (clock),
      .reset (reset),
      .csr   (csr_chan),
      .cfg   (cfg)
   );

   issa_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rdata   (mem_rdata)
   );

   issa_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req       (req_chan),
      .rsp       (rsp_chan),
      .mem_req   (mem_req),
      .mem_rdata (mem_rdata)
   );

`ifndef SYNTHESIS
   // Store writes come only from accepted load requests.
   a_write_from_load : assert property (@(posedge clock) disable iff (reset)
      (mem_req.en && mem_req.we) |->
         (req_chan.valid && req_chan.ready && req_chan.command == CMD_LOAD))
      else $error("store written without an accepted load request");

   // While neighbours are being read no new request is taken.
   a_no_accept_during_read : assert property (@(posedge clock) disable iff (reset)
      (mem_req.en && !mem_req.we) |-> !req_chan.ready)
      else $error("request ready while the store is being read");

   // A clipped result sits exactly on one of the range limits.
   a_saturated_at_limit : assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.saturated) |->
         (rsp_chan.sum_value == {1'b0, {(PIX_W-1){1'b1}}} ||
          rsp_chan.sum_value == {1'b1, {(PIX_W-1){1'b0}}}))
      else $error("saturated result not at a range limit");
`endif

endmodule

### rtl/core/issa_regs.sv
// ----------------------------------------------------------------------------
// issa_regs: configuration registers
// Holds the programmed registers and derives the integer shifts, fractional
// weights and clamp limits used by the engine.
// ----------------------------------------------------------------------------
module issa_regs import issa_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   issa_csr_if.sink   csr,
   output cfg_type    cfg
);

   logic                      mode_ff, mode_in;
   logic signed [SHIFT_W-1:0] shift_x_ff, shift_x_in;
   logic signed [SHIFT_W-1:0] shift_y_ff, shift_y_in;
   logic signed [GAIN_W-1:0]  gain_ff, gain_in;
   logic [DIM_W-1:0]          width_ff, width_in;
   logic [DIM_W-1:0]          height_ff, height_in;
   logic                      enable_ff, enable_in;

   logic signed [RND_W-1:0]   round_x;
   logic signed [RND_W-1:0]   round_y;

   assign csr.ready = 1'b1;

   always_comb begin
      mode_in     = mode_ff;
      shift_x_in  = shift_x_ff;
      shift_y_in  = shift_y_ff;
      gain_in     = gain_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      enable_in   = enable_ff;
      if (csr.valid) begin
         case (csr.index)
            CSR_INTERP_MODE: mode_in    = csr.data[0];
            CSR_SHIFT_X:     shift_x_in = csr.data[SHIFT_W-1:0];
            CSR_SHIFT_Y:     shift_y_in = csr.data[SHIFT_W-1:0];
            CSR_GAIN:        gain_in    = csr.data[GAIN_W-1:0];
            CSR_WIDTH:       width_in   = csr.data[DIM_W-1:0];
            CSR_HEIGHT:      height_in  = csr.data[DIM_W-1:0];
            CSR_ENABLE:      enable_in  = csr.data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= 1'b0;
         shift_x_ff <= '0;
         shift_y_ff <= '0;
         gain_ff    <= GAIN_W'(65536);
         width_ff   <= DIM_W'(256);
         height_ff  <= DIM_W'(256);
         enable_ff  <= 1'b1;
      end else begin
         mode_ff    <= mode_in;
         shift_x_ff <= shift_x_in;
         shift_y_ff <= shift_y_in;
         gain_ff    <= gain_in;
         width_ff   <= width_in;
         height_ff  <= height_in;
         enable_ff  <= enable_in;
      end
   end

   // Nearest mode rounds the shift to whole pixels; linear mode floors it and
   // keeps the fraction as the interpolation weight.
   assign round_x = {shift_x_ff[SHIFT_W-1], shift_x_ff} + RND_W'(HALF);
   assign round_y = {shift_y_ff[SHIFT_W-1], shift_y_ff} + RND_W'(HALF);

   always_comb begin
      cfg.interp_mode = mode_ff;
      cfg.enable      = enable_ff;
      cfg.gain        = gain_ff;
      if (mode_ff) begin
         cfg.dx = {shift_x_ff[SHIFT_W-1], shift_x_ff[SHIFT_W-1:FRAC_BITS]};
         cfg.dy = {shift_y_ff[SHIFT_W-1], shift_y_ff[SHIFT_W-1:FRAC_BITS]};
         cfg.rx = shift_x_ff[FRAC_BITS-1:0];
         cfg.ry = shift_y_ff[FRAC_BITS-1:0];
      end else begin
         cfg.dx = round_x[RND_W-1:FRAC_BITS];
         cfg.dy = round_y[RND_W-1:FRAC_BITS];
         cfg.rx = '0;
         cfg.ry = '0;
      end

      // A zero size behaves as one pixel, an oversized one as the store size.
      if (width_ff == '0) begin
         cfg.col_max = '0;
      end else if (int'(width_ff) > MAX_WIDTH) begin
         cfg.col_max = COL_W'(MAX_WIDTH - 1);
      end else begin
         cfg.col_max = COL_W'(width_ff - 1'b1);
      end
      if (height_ff == '0) begin
         cfg.row_max = '0;
      end else if (int'(height_ff) > MAX_HEIGHT) begin
         cfg.row_max = ROW_W'(MAX_HEIGHT - 1);
      end else begin
         cfg.row_max = ROW_W'(height_ff - 1'b1);
      end
   end

endmodule

### rtl/core/issa_store.sv
// ----------------------------------------------------------------------------
// issa_store: window store
// Single-port synchronous memory holding one window of the source frame,
// entry at row * MAX_WIDTH + column, with registered read data.
// ----------------------------------------------------------------------------
module issa_store import issa_pkg::*; (
   input  logic             clock,
   input  mem_req_type      mem_req,
   output logic [PIX_W-1:0] rdata
);

   logic [PIX_W-1:0] mem [DEPTH];
   logic [PIX_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_req.en) begin
         if (mem_req.we) begin
            mem[mem_req.addr] <= mem_req.wdata;
         end else begin
            rdata_ff <= mem[mem_req.addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

### rtl/core/issa_engine.sv
// ----------------------------------------------------------------------------
// issa_engine: request sequencer and datapath
// Writes loads into the store, reads up to four neighbours per accumulate,
// forms the weighted sum, applies the gain and saturates into the response
// register.
// ----------------------------------------------------------------------------
module issa_engine import issa_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   issa_req_if.sink         req,
   issa_rsp_if.source       rsp,
   output mem_req_type      mem_req,
   input  logic [PIX_W-1:0] mem_rdata
);

   state_type                 state_ff, state_in;
   logic [1:0]                step_ff, step_in;
   logic signed [PIX_W-1:0]   val_ff, val_in;
   logic [COL_W-1:0]          col_ff, col_in;
   logic [ROW_W-1:0]          row_ff, row_in;
   logic                      colpos_ff, colpos_in;
   logic                      rowpos_ff, rowpos_in;
   logic                      pend_ff, pend_in;
   logic [WT_W-1:0]           w_ff, w_in;
   logic                      prodv_ff, prodv_in;
   logic signed [ACC_W-1:0]   prod_ff, prod_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [GPROD_W-1:0] gprod_ff, gprod_in;
   logic signed [TERM_W-1:0]  term_ff, term_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [PIX_W-1:0]   rsp_sum_ff, rsp_sum_in;
   logic                      rsp_sat_ff, rsp_sat_in;

   logic signed [DIFF_W-1:0]  diff_x, diff_y;
   logic [COL_W-1:0]          col_new;
   logic [ROW_W-1:0]          row_new;
   logic                      dc, dr;
   logic [WT1_W-1:0]          wx, wy;
   logic [2*WT1_W-1:0]        wprod;
   logic [COL_W-1:0]          rd_col;
   logic [ROW_W-1:0]          rd_row;
   logic signed [PIX_W-1:0]   interp;
   logic signed [GPROD_W-1:0] gsum;
   logic signed [TOTAL_W-1:0] total;
   logic                      accept;
   logic                      load_ok;

   assign req.ready     = (state_ff == ST_IDLE);
   assign accept        = req.valid && req.ready;
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.sum_value = rsp_sum_ff;
   assign rsp.saturated = rsp_sat_ff;

   // Source position, clamped to the window
   assign diff_x = DIFF_W'($signed({1'b0, req.pos_x})) - DIFF_W'(cfg.dx);
   assign diff_y = DIFF_W'($signed({1'b0, req.pos_y})) - DIFF_W'(cfg.dy);

   always_comb begin
      if (diff_x < 0) begin
         col_new = '0;
      end else if (int'(diff_x) > int'(cfg.col_max)) begin
         col_new = cfg.col_max;
      end else begin
         col_new = COL_W'(diff_x);
      end
      if (diff_y < 0) begin
         row_new = '0;
      end else if (int'(diff_y) > int'(cfg.row_max)) begin
         row_new = cfg.row_max;
      end else begin
         row_new = ROW_W'(diff_y);
      end
   end

   // Neighbour order: up-left, up, left, centre. On the first row or column
   // the outer neighbour gets no weight and the centre takes all of it.
   assign dc = ~step_ff[0];
   assign dr = ~step_ff[1];

   always_comb begin
      if (dc) begin
         wx = colpos_ff ? {1'b0, cfg.rx} : '0;
      end else begin
         wx = colpos_ff ? WT1_W'(ONE) - {1'b0, cfg.rx} : WT1_W'(ONE);
      end
      if (dr) begin
         wy = rowpos_ff ? {1'b0, cfg.ry} : '0;
      end else begin
         wy = rowpos_ff ? WT1_W'(ONE) - {1'b0, cfg.ry} : WT1_W'(ONE);
      end
   end

   assign wprod  = wx * wy;
   assign rd_col = col_ff - COL_W'(dc);
   assign rd_row = row_ff - ROW_W'(dr);

   assign interp  = acc_ff[2*FRAC_BITS+PIX_W-1:2*FRAC_BITS];
   assign gsum    = gprod_ff + GPROD_W'(GAIN_ROUND);
   assign total   = TOTAL_W'(val_ff) + TOTAL_W'(term_ff);
   assign load_ok = (int'(req.pos_x) < MAX_WIDTH) && (int'(req.pos_y) < MAX_HEIGHT);

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      val_in       = val_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      colpos_in    = colpos_ff;
      rowpos_in    = rowpos_ff;
      pend_in      = 1'b0;
      w_in         = w_ff;
      prodv_in     = pend_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      gprod_in     = gprod_ff;
      term_in      = term_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_sum_in   = rsp_sum_ff;
      rsp_sat_in   = rsp_sat_ff;
      mem_req      = '0;

      // Read data arrives in the cycle after the request; the product is
      // registered in prod_ff and then added into acc_ff.
      if (pend_ff) begin
         prod_in = $signed(mem_rdata) * $signed({1'b0, w_ff});
      end
      if (prodv_ff) begin
         acc_in = acc_ff + prod_ff;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req.command == CMD_LOAD) begin
                  mem_req.en    = load_ok;
                  mem_req.we    = 1'b1;
                  mem_req.addr  = ADDR_W'(req.pos_y) * ADDR_W'(MAX_WIDTH)
                                + ADDR_W'(req.pos_x);
                  mem_req.wdata = req.pixel_value;
               end else begin
                  val_in    = req.pixel_value;
                  col_in    = col_new;
                  row_in    = row_new;
                  colpos_in = (col_new != '0);
                  rowpos_in = (row_new != '0);
                  step_in   = '0;
                  acc_in    = ACC_W'(ACC_ROUND);
                  if (cfg.enable) begin
                     state_in = ST_READ;
                  end else begin
                     term_in  = '0;
                     state_in = ST_SUM;
                  end
               end
            end
         end
         ST_READ: begin
            if (wprod != '0) begin
               mem_req.en   = 1'b1;
               mem_req.addr = ADDR_W'(rd_row) * ADDR_W'(MAX_WIDTH) + ADDR_W'(rd_col);
               pend_in      = 1'b1;
               w_in         = wprod[WT_W-1:0];
            end
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               step_in  = '0;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd1) begin
               step_in  = '0;
               state_in = ST_GAIN;
            end
         end
         ST_GAIN: begin
            gprod_in = interp * cfg.gain;
            state_in = ST_TERM;
         end
         ST_TERM: begin
            term_in  = gsum[GPROD_W-1:GAIN_FRAC];
            state_in = ST_SUM;
         end
         ST_SUM: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               if (total[TOTAL_W-1:PIX_W-1] == '0 || total[TOTAL_W-1:PIX_W-1] == '1) begin
                  rsp_sum_in = total[PIX_W-1:0];
                  rsp_sat_in = 1'b0;
               end else begin
                  rsp_sum_in = total[TOTAL_W-1] ? {1'b1, {(PIX_W-1){1'b0}}}
                                                : {1'b0, {(PIX_W-1){1'b1}}};
                  rsp_sat_in = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         pend_ff      <= 1'b0;
         prodv_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         pend_ff      <= pend_in;
         prodv_ff     <= prodv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff     <= val_in;
      col_ff     <= col_in;
      row_ff     <= row_in;
      colpos_ff  <= colpos_in;
      rowpos_ff  <= rowpos_in;
      w_ff       <= w_in;
      prod_ff    <= prod_in;
      acc_ff     <= acc_in;
      gprod_ff   <= gprod_in;
      term_ff    <= term_in;
      rsp_sum_ff <= rsp_sum_in;
      rsp_sat_ff <= rsp_sat_in;
   end

endmodule

### dv/image_shift_scale_accumulate_tb.sv
// ----------------------------------------------------------------------------
// image_shift_scale_accumulate_tb: self-checking bench for the shift and add
// Loads source pixels into the window store and sends accumulate requests
// under many register settings. A short table of directed requests comes
// first, then random windows, shifts, gains and pixels. Every result is
// checked against the directed table's value or a bit-exact predictor kept
// inside the bench, with random gaps on the request side and random stalls on the response side.
// ----------------------------------------------------------------------------
module image_shift_scale_accumulate_tb import issa_pkg::*;;

   localparam int CYCLE_LIMIT   = 2000000;
   localparam int SETTLE_CYCLES = 16;
   localparam int ITEM_TARGET   = 1000;
   localparam int NUM_STEPS     = 42;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_INDEX = 3'd7;
   localparam longint PIX_MAX = 64'sd2147483647;
   localparam longint PIX_MIN = -64'sd2147483648;

   typedef struct packed {
      logic [PIX_W-1:0] sum;
      logic             sat;
   } sum_result_type;

   typedef enum logic [1:0] {
      STEP_CSR,
      STEP_LOAD,
      STEP_ACCUM,
      STEP_FILL
   } step_kind_type;

   typedef struct {
      step_kind_type        kind;
      logic [CSR_IDX_W-1:0] idx;
      logic [POS_W-1:0]     x;
      logic [POS_W-1:0]     y;
      logic [PIX_W-1:0]     value;
      bit                   typed;
      logic [PIX_W-1:0]     want_sum;
      bit                   want_sat;
   } step_type;

   logic clock;
   logic reset;

   issa_req_if req_chan ();
   issa_rsp_if rsp_chan ();
   issa_csr_if csr_chan ();

   image_shift_scale_accumulate u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // Register copy and window store copy used for prediction.
   logic                      cfg_interp;
   logic signed [SHIFT_W-1:0] cfg_shift_x;
   logic signed [SHIFT_W-1:0] cfg_shift_y;
   logic signed [GAIN_W-1:0]  cfg_gain;
   logic [DIM_W-1:0]          cfg_width;
   logic [DIM_W-1:0]          cfg_height;
   logic                      cfg_enable;
   logic [PIX_W-1:0]          window_copy [DEPTH];
   bit                        loaded [DEPTH];

   sum_result_type expected_sums [$];

   int  error_count;
   int  cycle_count;
   int  loads_sent;
   int  accums_sent;
   int  results_checked;
   int  saturated_seen;
   int  settings_used;
   int  rsp_stretch;
   bit  steady_phase;

   step_type directed_steps [NUM_STEPS] = '{
      '{STEP_LOAD,  '0,              8'd0,   8'd0,   32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
      '{STEP_LOAD,  '0,              8'd255, 8'd255, 32'h8000_0000, 1'b0, 32'h0, 1'b0},
      '{STEP_LOAD,  '0,              8'd17,  8'd200, 32'h0000_0100, 1'b0, 32'h0, 1'b0},
      '{STEP_ACCUM, '0,              8'd0,   8'd0,   32'h0000_0000, 1'b1, 32'h7FFF_FFFF, 1'b0},
      '{STEP_ACCUM, '0,              8'd0,   8'd0,   32'h0000_0001, 1'b1, 32'h7FFF_FFFF, 1'b1},
      '{STEP_ACCUM, '0,              8'd255, 8'd255, 32'hFFFF_FFFF, 1'b1, 32'h8000_0000, 1'b1},
      '{STEP_ACCUM, '0,              8'd255, 8'd255, 32'h7FFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b0},
      '{STEP_ACCUM, '0,              8'd17,  8'd200, 32'h0000_0100, 1'b1, 32'h0000_0200, 1'b0},
      '{STEP_CSR,   CSR_GAIN,        8'd0,   8'd0,   32'h0080_0000, 1'b0, 32'h0, 1'b0},
      '{STEP_ACCUM, '0,              8'd255, 8'd255, 32'h0000_0000, 1'b1, 32'h7FFF_FFFF, 1'b1},
      '{STEP_ACCUM, '0,              8'd17,  8'd200, 32'h0000_0000, 1'b1, 32'hFFFF_8000, 1'b0},
      '{STEP_CSR,   CSR_GAIN,        8'd0,   8'd0,   32'h007F_FFFF, 1'b0, 32'h0, 1'b0},
      '{STEP_ACCUM, '0,              8'd0,   8'd0,   32'h8000_0000, 1'b0, 32'h0, 1'b0},
      '{STEP_CSR,   CSR_ENABLE,      8'd0,   8'd0,   32'h0000_0000, 1'b0, 32'h0, 1'b0},
      '{STEP_ACCUM, '0,              8'd0,   8'd0,   32'h1234_5678, 1'b1, 32'h1234_5678, 1'b0},
      '{STEP_ACCUM, '0,              8'd255, 8'd255, 32'h8000_0000, 1'b1, 32'h8000_0000, 1'b0},
      '{STEP_CSR,   CSR_ENABLE,      8'd0,   8'd0,   32'h0000_0001, 1'b0, 32'h0, 1'b0},
      '{STEP_CSR,   CSR_GAIN,        8'd0,   8'd0,   32'h0001_0000, 1'b0, 32'h0, 1'b0},
      '{STEP_CSR,   CSR_SPARE_INDEX, 8'd0,   8'd0,   32'h00FF_FFFF, 1'b0, 32'h0, 1'b0},
      '{STEP_ACCUM, '0,              8'd17,  8'd200, 32'h0000_0005, 1'b1, 32'h0000_0105, 1'b0},
      '{STEP_CSR,   CSR_WIDTH,       8'd0,   8'd0,   32'h0000_0000, 1'b0, 32'h0, 1'b0},
      '{STEP_CSR,   CSR_HEIGHT,      8'd0,   8'd0,   32'h0000_0000, 1'b0, 32'h0, 1'b0},
      '{STEP_CSR,   CSR_INTERP_MODE, 8'd0,   8'd0,   32'h0000_0001, 1'b0, 32'h0, 1'b0},
      '{STEP_CSR,   CSR_SHIFT_X,     8'd0,   8'd0,   32'h0001_0000, 1'b0, 32'h0, 1'b0},
      '{STEP_CSR,   CSR_SHIFT_Y,     8'd0,   8'd0,   32'h0000_FFFF, 1'b0, 32'h0, 1'b0},
      '{STEP_ACCUM, '0,              8'd200, 8'd3,   32'h0000_0000, 1'b1, 32'h7FFF_FFFF, 1'b0},
      '{STEP_CSR,   CSR_WIDTH,       8'd0,   8'd0,   32'h0000_01FF, 1'b0, 32'h0, 1'b0},
      '{STEP_CSR,   CSR_HEIGHT,      8'd0,   8'd0,   32'h0000_0002, 1'b0, 32'h0, 1'b0},
      '{STEP_FILL,  '0,              8'd0,   8'd0,   32'h0000_0000, 1'b0, 32'h0, 1'b0},
      '{STEP_CSR,   CSR_SHIFT_X,     8'd0,   8'd0,   32'h0000_0080, 1'b0, 32'h0, 1'b0},
      '{STEP_CSR,   CSR_SHIFT_Y,     8'd0,   8'd0,   32'h0001_FF80, 1'b0, 32'h0, 1'b0},
      '{STEP_ACCUM, '0,              8'd100, 8'd0,   32'h0000_1000, 1'b0, 32'h0, 1'b0},
      '{STEP_ACCUM, '0,              8'd0,   8'd0,   32'hFFFF_F000, 1'b0, 32'h0, 1'b0},
      '{STEP_CSR,   CSR_SHIFT_Y,     8'd0,   8'd0,   32'h0000_0000, 1'b0, 32'h0, 1'b0},
      '{STEP_ACCUM, '0,              8'd100, 8'd0,   32'h0000_0000, 1'b0, 32'h0, 1'b0},
      '{STEP_CSR,   CSR_INTERP_MODE, 8'd0,   8'd0,   32'h0000_0000, 1'b0, 32'h0, 1'b0},
      '{STEP_ACCUM, '0,              8'd100, 8'd1,   32'h0000_0000, 1'b0, 32'h0, 1'b0},
      '{STEP_CSR,   CSR_WIDTH,       8'd0,   8'd0,   32'h0000_0001, 1'b0, 32'h0, 1'b0},
      '{STEP_CSR,   CSR_HEIGHT,      8'd0,   8'd0,   32'h0000_0100, 1'b0, 32'h0, 1'b0},
      '{STEP_FILL,  '0,              8'd0,   8'd0,   32'h0000_0000, 1'b0, 32'h0, 1'b0},
      '{STEP_ACCUM, '0,              8'd0,   8'd255, 32'h0000_0000, 1'b0, 32'h0, 1'b0},
      '{STEP_ACCUM, '0,              8'd255, 8'd0,   32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0}
   };

   always #6 clock = ~clock;

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------
   function automatic int window_dim(logic [DIM_W-1:0] d, int limit);
      if (d == 0)
         return 1;
      return (d > limit) ? limit : int'(d);
   endfunction

   function automatic longint clamp_to(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic longint stored_pixel(longint col, longint row);
      return $signed(window_copy[row * MAX_WIDTH + col]);
   endfunction

   function automatic void apply_register(logic [CSR_IDX_W-1:0] idx,
                                          logic [CSR_DATA_W-1:0] value);
      case (idx)
         CSR_INTERP_MODE: cfg_interp  = value[0];
         CSR_SHIFT_X:     cfg_shift_x = value[SHIFT_W-1:0];
         CSR_SHIFT_Y:     cfg_shift_y = value[SHIFT_W-1:0];
         CSR_GAIN:        cfg_gain    = value[GAIN_W-1:0];
         CSR_WIDTH:       cfg_width   = value[DIM_W-1:0];
         CSR_HEIGHT:      cfg_height  = value[DIM_W-1:0];
         CSR_ENABLE:      cfg_enable  = value[0];
         default: ;
      endcase
   endfunction

   function automatic sum_result_type shifted_sum(logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                                                  logic [PIX_W-1:0] value);
      longint base, sx, sy, g, dx, dy, rx, ry, col, row, acc, interp, term, total;
      sum_result_type res;
      base = $signed(value);
      res.sum = value;
      res.sat = 1'b0;
      if (!cfg_enable)
         return res;
      sx = cfg_shift_x;
      sy = cfg_shift_y;
      g  = cfg_gain;
      if (!cfg_interp) begin
         dx = (sx + HALF) >>> FRAC_BITS;
         dy = (sy + HALF) >>> FRAC_BITS;
         rx = 0;
         ry = 0;
      end else begin
         dx = sx >>> FRAC_BITS;
         dy = sy >>> FRAC_BITS;
         rx = sx - dx * ONE;
         ry = sy - dy * ONE;
      end
      col = x;
      row = y;
      col = clamp_to(col - dx, 0, window_dim(cfg_width, MAX_WIDTH) - 1);
      row = clamp_to(row - dy, 0, window_dim(cfg_height, MAX_HEIGHT) - 1);
      if (!cfg_interp) begin
         interp = stored_pixel(col, row);
      end else begin
         // At the left and top edges the missing neighbours drop out.
         if (col > 0 && row > 0)
            acc = rx * ry * stored_pixel(col - 1, row - 1)
                + (ONE - rx) * ry * stored_pixel(col, row - 1)
                + rx * (ONE - ry) * stored_pixel(col - 1, row)
                + (ONE - rx) * (ONE - ry) * stored_pixel(col, row);
         else if (col > 0)
            acc = (rx * stored_pixel(col - 1, row) + (ONE - rx) * stored_pixel(col, row))
                  * ONE;
         else if (row > 0)
            acc = (ry * stored_pixel(col, row - 1) + (ONE - ry) * stored_pixel(col, row))
                  * ONE;
         else
            acc = stored_pixel(col, row) * ONE * ONE;
         interp = (acc + ACC_ROUND) >>> (2 * FRAC_BITS);
      end
      term  = (interp * g + GAIN_ROUND) >>> GAIN_FRAC;
      total = base + term;
      if (total > PIX_MAX) begin
         total   = PIX_MAX;
         res.sat = 1'b1;
      end else if (total < PIX_MIN) begin
         total   = PIX_MIN;
         res.sat = 1'b1;
      end
      res.sum = total[PIX_W-1:0];
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // Random choices
   // ------------------------------------------------------------------------
   function automatic int gap_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70)
         return $urandom_range(1, 3);
      if (pick < 95)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [PIX_W-1:0] pick_pixel();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 14)
         return $urandom;
      if (pick < 17)
         return PIX_W'($urandom_range(0, 8192) - 4096);
      case ($urandom_range(0, 3))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h0000_0000;
         default: return 32'hFFFF_FFFF;
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_shift();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 14)
         return CSR_DATA_W'(SHIFT_W'($urandom_range(0, 3072) - 1536));
      if (pick < 17)
         return CSR_DATA_W'(SHIFT_W'($urandom));
      case ($urandom_range(0, 4))
         0:       return 24'h01_0000;
         1:       return 24'h00_FFFF;
         2:       return 24'h00_0080;
         3:       return 24'h01_FF80;
         default: return 24'h00_0000;
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_gain();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 6)
         return CSR_DATA_W'($urandom_range(0, 524288) - 262144);
      if (pick < 8)
         return CSR_DATA_W'($urandom);
      case ($urandom_range(0, 3))
         0:       return 24'h80_0000;
         1:       return 24'h7F_FFFF;
         2:       return 24'h01_0000;
         default: return 24'h00_0000;
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Driving
   // ------------------------------------------------------------------------
   task automatic send_request(input cmd_type cmd, input logic [POS_W-1:0] x,
                               input logic [POS_W-1:0] y, input logic [PIX_W-1:0] value,
                               input bit typed, input sum_result_type want);
      int gap;
      @(negedge clock);
      req_chan.valid       = 1'b1;
      req_chan.command     = cmd;
      req_chan.pos_x       = x;
      req_chan.pos_y       = y;
      req_chan.pixel_value = value;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      if (cmd == CMD_LOAD) begin
         window_copy[int'(y) * MAX_WIDTH + int'(x)] = value;
         loaded[int'(y) * MAX_WIDTH + int'(x)]      = 1'b1;
         loads_sent++;
      end else begin
         expected_sums.push_back(typed ? want : shifted_sum(x, y, value));
         accums_sent++;
      end
      gap = (steady_phase || $urandom_range(0, 1) == 0) ? 0 : gap_length();
      if (gap > 0) begin
         @(negedge clock);
         req_chan.valid       = 1'b0;
         req_chan.command     = 1'($urandom_range(0, 1));
         req_chan.pos_x       = POS_W'($urandom);
         req_chan.pos_y       = POS_W'($urandom);
         req_chan.pixel_value = $urandom;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // Holds the request side back until every outstanding result is in.
   task automatic drain_results();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (expected_sums.size() != 0)
         @(posedge clock);
   endtask

   task automatic settle_block();
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_chan.valid = 1'b1;
      csr_chan.index = idx;
      csr_chan.data  = value;
      do @(posedge clock); while (csr_chan.ready !== 1'b1);
      apply_register(idx, value);
      @(negedge clock);
      csr_chan.valid = 1'b0;
   endtask

   // Loads every window entry not yet written, so that no accumulate can
   // ever read an undefined store entry.
   task automatic fill_window();
      int cols;
      int rows;
      cols = window_dim(cfg_width, MAX_WIDTH);
      rows = window_dim(cfg_height, MAX_HEIGHT);
      for (int r = 0; r < rows; r++)
         for (int c = 0; c < cols; c++)
            if (!loaded[r * MAX_WIDTH + c])
               send_request(CMD_LOAD, POS_W'(c), POS_W'(r), pick_pixel(), 1'b0, '0);
   endtask

   task automatic choose_setting();
      logic [DIM_W-1:0] w;
      logic [DIM_W-1:0] h;
      int               pick;
      pick = $urandom_range(0, 9);
      if (pick < 8) begin
         w = DIM_W'($urandom_range(1, 12));
         h = DIM_W'($urandom_range(1, 12));
      end else if (pick == 8) begin
         // Wide and flat, with out-of-range sizes now and then.
         w = ($urandom_range(0, 1) != 0) ? DIM_W'(MAX_WIDTH) : DIM_W'($urandom_range(257, 511));
         h = DIM_W'($urandom_range(0, 3));
      end else begin
         w = DIM_W'($urandom_range(0, 3));
         h = ($urandom_range(0, 1) != 0) ? DIM_W'(MAX_HEIGHT) : DIM_W'($urandom_range(257, 511));
      end
      csr_write(CSR_INTERP_MODE, CSR_DATA_W'($urandom_range(0, 1)));
      csr_write(CSR_SHIFT_X, pick_shift());
      csr_write(CSR_SHIFT_Y, pick_shift());
      csr_write(CSR_GAIN, pick_gain());
      csr_write(CSR_WIDTH, CSR_DATA_W'(w));
      csr_write(CSR_HEIGHT, CSR_DATA_W'(h));
      csr_write(CSR_ENABLE, CSR_DATA_W'($urandom_range(0, 9) != 0));
      if ($urandom_range(0, 3) == 0)
         csr_write(CSR_SPARE_INDEX, CSR_DATA_W'($urandom));
      settings_used++;
   endtask

   task automatic random_request();
      int               cols;
      int               rows;
      logic [POS_W-1:0] x;
      logic [POS_W-1:0] y;
      cols = window_dim(cfg_width, MAX_WIDTH);
      rows = window_dim(cfg_height, MAX_HEIGHT);
      if ($urandom_range(0, 9) < 3) begin
         if ($urandom_range(0, 2) != 0) begin
            x = POS_W'($urandom_range(0, cols - 1));
            y = POS_W'($urandom_range(0, rows - 1));
         end else begin
            x = POS_W'($urandom);
            y = POS_W'($urandom);
         end
         send_request(CMD_LOAD, x, y, pick_pixel(), 1'b0, '0);
      end else begin
         // Mostly near the window so that the edge cases come up often.
         if ($urandom_range(0, 3) != 0) begin
            x = POS_W'($urandom_range(0, (cols + 3 > 255) ? 255 : cols + 3));
            y = POS_W'($urandom_range(0, (rows + 3 > 255) ? 255 : rows + 3));
         end else begin
            x = POS_W'($urandom);
            y = POS_W'($urandom);
         end
         send_request(CMD_ACCUM, x, y, pick_pixel(), 1'b0, '0);
      end
      if ($urandom_range(0, 49) == 0)
         drain_results();
   endtask

   // ------------------------------------------------------------------------
   // Response side: random stalls, with long stretches of steady readiness
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (rsp_stretch > 0) begin
         rsp_stretch--;
      end else if (rsp_chan.ready) begin
         rsp_chan.ready = 1'b0;
         rsp_stretch    = gap_length() - 1;
      end else begin
         rsp_chan.ready = 1'b1;
         rsp_stretch    = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                       : $urandom_range(0, 8);
      end
   end

   task automatic report_mismatch(input string what, input sum_result_type want);
      error_count++;
      if (error_count <= 10)
         $display("[%0d] %s: expected sum %h sat %b, got sum %h sat %b", cycle_count, what,
                  want.sum, want.sat, rsp_chan.sum_value, rsp_chan.saturated);
   endtask

   always @(posedge clock) begin : check_results
      sum_result_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         results_checked++;
         if (rsp_chan.saturated === 1'b1)
            saturated_seen++;
         if (expected_sums.size() == 0) begin
            report_mismatch("result with no request outstanding", '0);
         end else begin
            want = expected_sums.pop_front();
            if (rsp_chan.sum_value !== want.sum || rsp_chan.saturated !== want.sat)
               report_mismatch("result mismatch", want);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d results outstanding", cycle_count,
                  expected_sums.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      clock                = 1'b0;
      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.command     = CMD_LOAD;
      req_chan.pos_x       = '0;
      req_chan.pos_y       = '0;
      req_chan.pixel_value = '0;
      rsp_chan.ready       = 1'b0;
      csr_chan.valid       = 1'b0;
      csr_chan.index       = CSR_INTERP_MODE;
      csr_chan.data        = '0;
      error_count          = 0;
      cycle_count          = 0;
      loads_sent           = 0;
      accums_sent          = 0;
      results_checked      = 0;
      saturated_seen       = 0;
      settings_used        = 0;
      rsp_stretch          = 0;
      steady_phase         = 1'b0;
      cfg_interp           = 1'b0;
      cfg_shift_x          = '0;
      cfg_shift_y          = '0;
      cfg_gain             = 24'sd65536;
      cfg_width            = DIM_W'(MAX_WIDTH);
      cfg_height           = DIM_W'(MAX_HEIGHT);
      cfg_enable           = 1'b1;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_steps[i]) begin
         case (directed_steps[i].kind)
            STEP_CSR: begin
               settle_block();
               csr_write(directed_steps[i].idx, directed_steps[i].value[CSR_DATA_W-1:0]);
            end
            STEP_LOAD, STEP_ACCUM: begin
               send_request((directed_steps[i].kind == STEP_LOAD) ? CMD_LOAD : CMD_ACCUM,
                            directed_steps[i].x, directed_steps[i].y,
                            directed_steps[i].value, directed_steps[i].typed,
                            {directed_steps[i].want_sum, directed_steps[i].want_sat});
            end
            default: fill_window();
         endcase
      end

      // The window fills count towards the total, so the random phase only
      // tops the run up to the intended number of requests.
      while (loads_sent + accums_sent < ITEM_TARGET) begin
         settle_block();
         choose_setting();
         fill_window();
         steady_phase = ($urandom_range(0, 4) == 0);
         repeat ($urandom_range(20, 80)) begin
            random_request();
         end
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d load and %0d accumulate requests over %0d random register settings.",
               loads_sent, accums_sent, settings_used);
      $display("Checked %0d results, %0d of them saturated, with %0d mismatches.",
               results_checked, saturated_seen, error_count);
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
